// ===== hw/rtl/pfc_pkg.sv =====
package pfc_pkg;

  localparam int NumLanes = 8;
  localparam int NumOuts  = 6;

  // Configuration register indexes.
  localparam logic [3:0] REG_FLOAT_ENCODING  = 4'd0;
  localparam logic [3:0] REG_CONTAINER_BYTES = 4'd1;
  localparam logic [3:0] REG_CHANNEL_COUNT   = 4'd2;
  localparam logic [3:0] REG_SURROUND_MODE   = 4'd3;

  // Container sizes and channel counts that select behavior.
  localparam logic [2:0] CONTAINER_16 = 3'd2;
  localparam logic [2:0] CONTAINER_24 = 3'd3;
  localparam logic [3:0] CH_MONO = 4'd1;
  localparam logic [3:0] CH_5_1  = 4'd6;
  localparam logic [3:0] CH_7_1  = 4'd8;

  // Fold coefficient 0.7071067811865476 held as 0x16A09E667F3BCD / 2^53,
  // split into a high and a low part so each product stays narrow.
  localparam logic [20:0] FOLD_K_HI = 21'h16A09E;
  localparam logic [31:0] FOLD_K_LO = 32'h667F3BCD;

  typedef struct packed {
    logic       float_encoding;
    logic [2:0] container_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/pfc_lane.sv =====
module pfc_lane (
  input  logic                clk,
  input  logic                load,
  input  pfc_pkg::cfg_t       cfg,
  input  logic [31:0]         raw,
  output logic signed [15:0]  conv
);
  import pfc_pkg::*;

  logic [7:0]         expo;
  logic [23:0]        mant;
  logic [7:0]         shamt;
  logic [23:0]        mag;
  logic signed [15:0] float_val;
  logic signed [15:0] int_val;
  logic signed [15:0] conv_next;

  always_comb begin
    expo = raw[30:23];
    mant = {1'b0, raw[22:0]};
    shamt = 8'd0;
    mag = 24'd0;
    float_val = 16'sd0;
    if (expo == 8'hFF) begin
      float_val = 16'sd0;
    end else if (expo >= 8'd127) begin
      float_val = raw[31] ? -16'sd32768 : 16'sd32767;
    end else begin
      // Denormals use the smallest normal exponent without the hidden bit.
      if (expo == 8'd0) begin
        shamt = 8'd134;
      end else begin
        mant[23] = 1'b1;
        shamt = 8'd135 - expo;
      end
      mag = (shamt >= 8'd32) ? 24'd0 : (mant >> shamt[4:0]);
      float_val = raw[31] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    end
  end

  always_comb begin
    priority if (cfg.container_bytes == CONTAINER_16) begin
      int_val = $signed(raw[15:0]);
    end else if (cfg.container_bytes == CONTAINER_24) begin
      int_val = $signed(raw[23:8]);
    end else begin
      int_val = $signed(raw[31:16]);
    end
  end

  assign conv_next = cfg.float_encoding ? float_val : int_val;

  always_ff @(posedge clk) begin
    if (load) begin
      conv <= conv_next;
    end
  end

endmodule

// ===== hw/rtl/pfc_fold.sv =====
module pfc_fold (
  input  logic                clk,
  input  logic                load,
  input  logic [16:0]         mag,
  input  logic                neg,
  output logic signed [15:0]  result
);
  import pfc_pkg::*;

  logic [48:0] prod_lo;
  logic [37:0] prod_hi;
  logic        neg_q;
  logic [53:0] lo_round;
  logic [38:0] total;
  logic [17:0] rmag;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_lo <= 49'(mag) * 49'(FOLD_K_LO);
      prod_hi <= 38'(mag) * 38'(FOLD_K_HI);
      neg_q   <= neg;
    end
  end

  // Adding one half at bit 52 rounds the magnitude half away from zero.
  always_comb begin
    lo_round = 54'(prod_lo) + (54'd1 << 52);
    total = 39'(prod_hi) + 39'(lo_round[53:32]);
    rmag = total[38:21];
    if (neg_q) begin
      result = (rmag > 18'd32768) ? -16'sd32768 : -$signed(rmag[15:0]);
    end else begin
      result = (rmag > 18'd32767) ? 16'sd32767 : $signed(rmag[15:0]);
    end
  end

endmodule

// ===== hw/rtl/pcm_frame_to_16bit_converter_unit.sv =====
// Each transfer passes the lane, select, fold product and output registers in turn.
// Throughput: one frame per cycle when not stalled; eight conversion lanes work in
// parallel and the 7.1 fold multiply is split over a product stage and a combine stage.
// Stages fill up behind a waiting result; the input stalls only once all four are full.
// Reset (rst, synchronous) empties the pipeline and restores the registers:
// integer PCM, 2-byte containers, 2 channels, stereo path.
module pcm_frame_to_16bit_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        sample_0,
  input  logic [31:0]        sample_1,
  input  logic [31:0]        sample_2,
  input  logic [31:0]        sample_3,
  input  logic [31:0]        sample_4,
  input  logic [31:0]        sample_5,
  input  logic [31:0]        sample_6,
  input  logic [31:0]        sample_7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_0,
  output logic signed [15:0] out_1,
  output logic signed [15:0] out_2,
  output logic signed [15:0] out_3,
  output logic signed [15:0] out_4,
  output logic signed [15:0] out_5
);
  import pfc_pkg::*;

  logic       float_encoding;
  logic [2:0] container_bytes;
  logic [3:0] channel_count;
  logic       surround_mode;
  cfg_t       lane_cfg;

  logic [31:0]        raw [NumLanes];
  logic signed [15:0] conv [NumLanes];

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 2: selected outputs and fold operands.
  logic signed [15:0] sel [NumOuts];
  logic signed [15:0] sel_next [NumOuts];
  logic               fold_en, fold_en_next;
  logic [16:0]        mag4, mag5, mag4_next, mag5_next;
  logic               neg4, neg5;
  logic signed [16:0] sum4, sum5;

  // Stage 3: values that bypass the fold.
  logic signed [15:0] pass [NumOuts];
  logic               fold_en3;
  logic signed [15:0] fold4, fold5;

  always_ff @(posedge clk) begin
    if (rst) begin
      float_encoding  <= 1'b0;
      container_bytes <= CONTAINER_16;
      channel_count   <= 4'd2;
      surround_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLOAT_ENCODING:  float_encoding  <= cfg_data[0];
        REG_CONTAINER_BYTES: container_bytes <= cfg_data[2:0];
        REG_CHANNEL_COUNT:   channel_count   <= cfg_data;
        REG_SURROUND_MODE:   surround_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lane_cfg = '{float_encoding: float_encoding, container_bytes: container_bytes};

  // A stage takes new data when it is empty or its contents move on.
  assign rdy4 = !out_valid || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  assign raw[0] = sample_0;
  assign raw[1] = sample_1;
  assign raw[2] = sample_2;
  assign raw[3] = sample_3;
  assign raw[4] = sample_4;
  assign raw[5] = sample_5;
  assign raw[6] = sample_6;
  assign raw[7] = sample_7;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pfc_lane u_lane (
      .clk  (clk),
      .load (rdy1 && in_valid),
      .cfg  (lane_cfg),
      .raw  (raw[g]),
      .conv (conv[g])
    );
  end

  // Channel mapping for the selected path.
  always_comb begin
    for (int i = 0; i < NumOuts; i++) begin
      sel_next[i] = 16'sd0;
    end
    fold_en_next = 1'b0;
    if (!surround_mode) begin
      sel_next[0] = conv[0];
      sel_next[1] = (channel_count == CH_MONO) ? conv[0] : conv[1];
    end else if (channel_count == CH_5_1 || channel_count == CH_7_1) begin
      for (int i = 0; i < NumOuts; i++) begin
        sel_next[i] = conv[i];
      end
      fold_en_next = (channel_count == CH_7_1);
    end
    sum4 = 17'(conv[4]) + 17'(conv[6]);
    sum5 = 17'(conv[5]) + 17'(conv[7]);
    mag4_next = sum4[16] ? 17'(-sum4) : 17'(sum4);
    mag5_next = sum5[16] ? 17'(-sum5) : 17'(sum5);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sel     <= sel_next;
      fold_en <= fold_en_next;
      mag4    <= mag4_next;
      mag5    <= mag5_next;
      neg4    <= sum4[16];
      neg5    <= sum5[16];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      pass     <= sel;
      fold_en3 <= fold_en;
    end
  end

  pfc_fold u_fold4 (
    .clk    (clk),
    .load   (rdy3 && v2),
    .mag    (mag4),
    .neg    (neg4),
    .result (fold4)
  );

  pfc_fold u_fold5 (
    .clk    (clk),
    .load   (rdy3 && v2),
    .mag    (mag5),
    .neg    (neg5),
    .result (fold5)
  );

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_0 <= pass[0];
      out_1 <= pass[1];
      out_2 <= pass[2];
      out_3 <= pass[3];
      out_4 <= fold_en3 ? fold4 : pass[4];
      out_5 <= fold_en3 ? fold5 : pass[5];
    end
  end

endmodule

// ===== tb/sv/tb_pcm_frame_to_16bit_converter_unit.sv =====
`timescale 1ns / 100ps

module tb_pcm_frame_to_16bit_converter_unit;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DEPTH = 4;
  localparam int NUM_PHASES = 24;
  localparam int FRAMES_PER_PHASE = 68;
  localparam int MAX_LOGGED = 200;

  localparam logic       INT_PCM = 1'b0;
  localparam logic       FLOAT_PCM = 1'b1;
  localparam logic [2:0] CONTAINER_32 = 3'd4;
  localparam logic [3:0] CH_STEREO = 4'd2;
  localparam logic       STEREO_PATH = 1'b0;
  localparam logic       SURROUND_PATH = 1'b1;
  localparam bit         FROM_MODEL = 1'b0;
  localparam bit         FIXED = 1'b1;
  localparam logic [31:0] FILL = 32'hA5C3_96F0;

  // -3 dB fold gain with 53 fraction bits.
  localparam logic [52:0] ROOT_HALF = 53'h16A09E667F3BCD;

  typedef logic [0:NumLanes-1][31:0] frame_in_t;
  typedef logic [0:NumOuts-1][15:0]  frame_out_t;

  typedef struct packed {
    logic       float_enc;
    logic [2:0] container;
    logic [3:0] channels;
    logic       surround;
    frame_in_t  samples;
    logic       fixed;
    frame_out_t want;
  } vector_t;

  localparam int NUM_VECTORS = 25;
  localparam vector_t VECTORS [NUM_VECTORS] = '{
    '{INT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'h0000_7FFF, 32'h0000_8000, {6{FILL}}}, FIXED, {16'h7FFF, 16'h8000, 64'h0}},
    '{INT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'hFFFF_0000, 32'h0000_FFFF, {6{FILL}}}, FIXED, {16'h0000, 16'hFFFF, 64'h0}},
    '{INT_PCM, CONTAINER_24, CH_STEREO, STEREO_PATH,
      {32'h0080_0000, 32'h007F_FFFF, {6{FILL}}}, FIXED, {16'h8000, 16'h7FFF, 64'h0}},
    '{INT_PCM, CONTAINER_32, CH_STEREO, STEREO_PATH,
      {32'h8000_0000, 32'h7FFF_FFFF, {6{FILL}}}, FIXED, {16'h8000, 16'h7FFF, 64'h0}},
    // Unlisted container sizes behave as 4-byte containers.
    '{INT_PCM, 3'd0, CH_STEREO, STEREO_PATH,
      {32'h1234_5678, 32'hFEDC_0000, {6{FILL}}}, FIXED, {16'h1234, 16'hFEDC, 64'h0}},
    '{INT_PCM, 3'd7, CH_STEREO, STEREO_PATH,
      {32'hABCD_0123, 32'h0001_7FFF, {6{FILL}}}, FIXED, {16'hABCD, 16'h0001, 64'h0}},
    '{INT_PCM, CONTAINER_16, CH_MONO, STEREO_PATH,
      {32'h0000_1234, 32'h0000_5555, {6{FILL}}}, FIXED, {16'h1234, 16'h1234, 64'h0}},
    '{INT_PCM, CONTAINER_16, 4'd0, STEREO_PATH,
      {32'h0000_0001, 32'h0000_FFFE, {6{FILL}}}, FIXED, {16'h0001, 16'hFFFE, 64'h0}},
    '{FLOAT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'h3F80_0000, 32'hBF80_0000, {6{FILL}}}, FIXED, {16'h7FFF, 16'h8000, 64'h0}},
    '{FLOAT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'h7F80_0000, 32'h7FC0_0000, {6{FILL}}}, FIXED, {16'h0000, 16'h0000, 64'h0}},
    '{FLOAT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'hFF80_0000, 32'h4700_0000, {6{FILL}}}, FIXED, {16'h0000, 16'h7FFF, 64'h0}},
    '{FLOAT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'h3F00_0000, 32'hBF00_0000, {6{FILL}}}, FIXED, {16'h4000, 16'hC000, 64'h0}},
    '{FLOAT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'h0000_0001, 32'h8000_0000, {6{FILL}}}, FIXED, {16'h0000, 16'h0000, 64'h0}},
    '{FLOAT_PCM, CONTAINER_16, CH_STEREO, STEREO_PATH,
      {32'h3F7F_FFFF, 32'h3800_0000, {6{FILL}}}, FIXED, {16'h7FFF, 16'h0001, 64'h0}},
    '{FLOAT_PCM, CONTAINER_24, CH_MONO, STEREO_PATH,
      {32'hBEFF_FFFF, 32'h3F80_0000, {6{FILL}}}, FROM_MODEL, '0},
    '{INT_PCM, CONTAINER_16, CH_5_1, SURROUND_PATH,
      {32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, FILL, FILL}, FIXED,
      {16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6}},
    '{INT_PCM, CONTAINER_16, CH_7_1, SURROUND_PATH,
      {32'h0, 32'hFFFF_FFFF, 32'h8000, 32'h7FFF, 32'h7FFF, 32'h8000, 32'h7FFF, 32'h8000},
      FIXED, {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}},
    '{INT_PCM, CONTAINER_16, CH_7_1, SURROUND_PATH,
      {{4{FILL}}, 32'h1, 32'h2, 32'h0, 32'hFFFF}, FROM_MODEL, '0},
    '{INT_PCM, CONTAINER_16, CH_7_1, SURROUND_PATH,
      {{4{FILL}}, 32'h3, 32'h8000, 32'h0, 32'h7FFF}, FROM_MODEL, '0},
    '{INT_PCM, CONTAINER_32, CH_7_1, SURROUND_PATH,
      {32'h4000_0000, 32'hC000_1111, FILL, FILL, 32'h2000_0000, 32'hA000_0000,
       32'h1234_5678, 32'hEDCB_A987}, FROM_MODEL, '0},
    '{FLOAT_PCM, CONTAINER_16, CH_7_1, SURROUND_PATH,
      {32'h3F80_0000, 32'hBF00_0000, 32'h3E80_0000, 32'h7FC0_0000, 32'h3F00_0000,
       32'hBF40_0000, 32'h3F00_0000, 32'hBF40_0000}, FROM_MODEL, '0},
    // A surround count other than six or eight silences every output.
    '{INT_PCM, CONTAINER_16, CH_STEREO, SURROUND_PATH,
      {32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 32'h7, 32'h8}, FIXED, '0},
    '{INT_PCM, CONTAINER_16, 4'd7, SURROUND_PATH, {8{FILL}}, FIXED, '0},
    '{INT_PCM, CONTAINER_16, 4'hF, SURROUND_PATH, {8{FILL}}, FIXED, '0},
    '{INT_PCM, CONTAINER_16, CH_7_1, STEREO_PATH,
      {32'h0000_8001, 32'h0000_7FFE, {6{FILL}}}, FROM_MODEL, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] sample_0 = '0, sample_1 = '0, sample_2 = '0, sample_3 = '0;
  logic [31:0] sample_4 = '0, sample_5 = '0, sample_6 = '0, sample_7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_0, out_1, out_2, out_3, out_4, out_5;

  // Register copies, starting at their reset values.
  logic       cfg_float = INT_PCM;
  logic [2:0] cfg_bytes = CONTAINER_16;
  logic [3:0] cfg_channels = CH_STEREO;
  logic       cfg_surround = STEREO_PATH;

  // A fixed expectation travels with its frame, so it is sampled on the same edge.
  logic       frame_fixed = FROM_MODEL;
  frame_out_t frame_fixed_want = '0;

  frame_out_t frames_due [$];
  frame_out_t seen_frame;
  frame_out_t due_frame;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  pcm_frame_to_16bit_converter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_0  (sample_0),
    .sample_1  (sample_1),
    .sample_2  (sample_2),
    .sample_3  (sample_3),
    .sample_4  (sample_4),
    .sample_5  (sample_5),
    .sample_6  (sample_6),
    .sample_7  (sample_7),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_0     (out_0),
    .out_1     (out_1),
    .out_2     (out_2),
    .out_3     (out_3),
    .out_4     (out_4),
    .out_5     (out_5)
  );

  always #2 clk = ~clk;

  function automatic int float_to_int16(logic [31:0] bits);
    int expo;
    int mag;
    logic [23:0] mant;
    expo = int'(bits[30:23]);
    mant = {1'b0, bits[22:0]};
    if (expo == 255) return 0;
    if (expo >= 127) return bits[31] ? -32768 : 32767;
    if (expo == 0) begin
      expo = 1;
    end else begin
      mant[23] = 1'b1;
    end
    mag = (135 - expo >= 32) ? 0 : int'(mant >> (135 - expo));
    return bits[31] ? -mag : mag;
  endfunction

  function automatic int to_int16(logic [31:0] raw);
    if (cfg_float) return float_to_int16(raw);
    case (cfg_bytes)
      CONTAINER_16: return int'($signed(raw[15:0]));
      CONTAINER_24: return int'($signed(raw[23:8]));
      default:      return int'($signed(raw[31:16]));
    endcase
  endfunction

  // Scales the exact pair sum by the fold gain, rounding half away from zero.
  function automatic int fold_pair(int a, int b);
    int sum;
    int r;
    logic [16:0] mag;
    logic [127:0] prod;
    sum = a + b;
    mag = (sum < 0) ? 17'(-sum) : 17'(sum);
    prod = 128'(mag) * 128'(ROOT_HALF) + (128'd1 << 52);
    r = int'(prod >> 53);
    if (sum < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic frame_out_t convert_frame(frame_in_t smp);
    int v [NumOuts];
    int i;
    frame_out_t res;
    v = '{default: 0};
    if (cfg_surround == STEREO_PATH) begin
      v[0] = to_int16(smp[0]);
      v[1] = (cfg_channels == CH_MONO) ? v[0] : to_int16(smp[1]);
    end else if (cfg_channels == CH_5_1 || cfg_channels == CH_7_1) begin
      for (i = 0; i < NumOuts; i++) v[i] = to_int16(smp[i]);
      if (cfg_channels == CH_7_1) begin
        v[4] = fold_pair(v[4], to_int16(smp[6]));
        v[5] = fold_pair(v[5], to_int16(smp[7]));
      end
    end
    for (i = 0; i < NumOuts; i++) res[i] = 16'(v[i]);
    return res;
  endfunction

  function automatic logic [31:0] rand_sample();
    int pick;
    int shift;
    logic [31:0] v;
    pick = $urandom_range(0, 9);
    v = $urandom;
    if (pick == 0) begin
      case ($urandom_range(0, 7))
        0: v = 32'h0000_0000;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'h8000_0000;
        3: v = 32'h7FFF_FFFF;
        4: v = 32'h0000_8000;
        5: v = 32'h0000_7FFF;
        6: v = 32'h7F80_0000;
        default: v = 32'hFF80_0001;
      endcase
    end else if (pick >= 4) begin
      if (cfg_float) begin
        // Keep most floats in the range that scales to a real value.
        v[30:23] = 8'($urandom_range(100, 130));
      end else begin
        shift = (cfg_bytes == CONTAINER_16) ? 0 : (cfg_bytes == CONTAINER_24) ? 8 : 16;
        v = (v & ((32'd1 << shift) - 32'd1)) | (32'($urandom_range(0, 64) - 32) << shift);
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_LOGGED) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_frame(input frame_in_t smp, input bit fixed, input frame_out_t want);
    in_valid <= 1'b1;
    {sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, sample_6, sample_7} <= smp;
    frame_fixed <= fixed;
    frame_fixed_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  // Writes all four registers with junk in the unused data bits, then an unused index.
  task automatic program_regs(input logic fe, input logic [2:0] cb, input logic [3:0] cc,
                              input logic sm);
    logic [3:0] idx [5];
    logic [3:0] dat [5];
    int k;
    idx = '{REG_FLOAT_ENCODING, REG_CONTAINER_BYTES, REG_CHANNEL_COUNT,
            REG_SURROUND_MODE, 4'($urandom_range(4, 15))};
    dat = '{{3'($urandom), fe}, {1'($urandom), cb}, cc, {3'($urandom), sm}, 4'($urandom)};
    for (k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= dat[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_float = fe;
    cfg_bytes = cb;
    cfg_channels = cc;
    cfg_surround = sm;
  endtask

  always @(posedge clk) begin
    cycles = cycles + 1;
    case (cycles[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= 1'($urandom_range(0, 1));
      2'd2: out_stall <= (cycles[1:0] != 2'd0);
      default: out_stall <= cycles[3];
    endcase
    if (!rst) begin
      if (in_valid && !in_stall) begin
        frames_due.push_back(frame_fixed ? frame_fixed_want :
          convert_frame({sample_0, sample_1, sample_2, sample_3,
                         sample_4, sample_5, sample_6, sample_7}));
      end
      if (out_valid && !out_stall) begin
        seen_frame = {out_0, out_1, out_2, out_3, out_4, out_5};
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with no frame pending", results_seen));
        end else begin
          due_frame = frames_due.pop_front();
          for (int i = 0; i < NumOuts; i++) begin
            if (seen_frame[i] !== due_frame[i]) begin
              report_mismatch($sformatf("result %0d out_%0d = %0d, want %0d", results_seen,
                                        i, $signed(seen_frame[i]), $signed(due_frame[i])));
            end
          end
        end
        results_seen++;
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    vector_t row;
    frame_in_t smp;
    logic [2:0] cb;
    logic [3:0] cc;
    logic sm;
    int left;
    int burst;
    bit dense;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first rows run on the reset register values.
    for (int r = 0; r < NUM_VECTORS; r++) begin
      row = VECTORS[r];
      if ({row.float_enc, row.container, row.channels, row.surround} !=
          {cfg_float, cfg_bytes, cfg_channels, cfg_surround}) begin
        pause_until_drained();
        program_regs(row.float_enc, row.container, row.channels, row.surround);
      end
      send_frame(row.samples, row.fixed, row.want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      pause_until_drained();
      case ($urandom_range(0, 4))
        0: cb = CONTAINER_16;
        1: cb = CONTAINER_24;
        2: cb = CONTAINER_32;
        default: cb = 3'($urandom);
      endcase
      sm = 1'((p / 2) % 2);
      if (sm == SURROUND_PATH) begin
        case ($urandom_range(0, 4))
          0: cc = CH_5_1;
          1: cc = 4'($urandom);
          default: cc = CH_7_1;
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: cc = CH_MONO;
          1: cc = 4'($urandom);
          default: cc = CH_STEREO;
        endcase
      end
      program_regs(1'(p % 2), cb, cc, sm);
      dense = ($urandom_range(0, 3) == 0);
      left = FRAMES_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && left > 0) begin
          for (int j = 0; j < NumLanes; j++) smp[j] = rand_sample();
          send_frame(smp, FROM_MODEL, '0);
          burst--;
          left--;
        end
        if (left > 0 && !dense) begin
          if ($urandom_range(0, 9) == 0) begin
            pause_until_drained();
          end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
        end
      end
    end

    pause_until_drained();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
